[rtl/tgv_dual_first_order_update_assert.svh]
// Assertion macros for the TGV dual step block.
// Each macro expects clk and rst in scope.
`ifndef TGV_DUAL_FIRST_ORDER_UPDATE_ASSERT_SVH
`define TGV_DUAL_FIRST_ORDER_UPDATE_ASSERT_SVH

// Same-cycle implication.
`define TGV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TGV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/tgv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgv_pkg
// Item types, register indexes and fixed constants of the TGV dual step.
// ----------------------------------------------------------------------------
package tgv_pkg;

  typedef struct packed {
    logic signed [31:0] pixel_here;
    logic signed [31:0] pixel_next_row;
    logic signed [31:0] pixel_next_col;
    logic signed [31:0] aux_first;
    logic signed [31:0] aux_second;
    logic signed [31:0] dual_first_in;
    logic signed [31:0] dual_second_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] dual_first_out;
    logic signed [31:0] dual_second_out;
    logic               was_projected;
  } out_item_t;

  typedef logic [0:0] reg_idx_t;

  localparam reg_idx_t REG_STEP_SIGMA  = 1'b0;
  localparam reg_idx_t REG_BALL_RADIUS = 1'b1;

  localparam logic [31:0] SIGMA_RESET  = 32'd18919;
  localparam logic [31:0] RADIUS_RESET = 32'd65536;

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  // root and quotient width, bits resolved per stage
  localparam int ROOT_BITS      = 32;
  localparam int BITS_PER_STAGE = 2;

endpackage

[rtl/tgv_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgv_if
// Valid/ready channels of the TGV dual step: pixel items, results, config.
// ----------------------------------------------------------------------------
interface tgv_pix_if;
  logic              valid;
  logic              ready;
  tgv_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tgv_res_if;
  logic               valid;
  logic               ready;
  tgv_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tgv_cfg_if;
  logic              valid;
  logic              ready;
  tgv_pkg::reg_idx_t index;
  logic [31:0]       data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/tgv_dual_first_order_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgv_dual_first_order_update
// Fused dual update p + sigma*(grad u - v) and projection onto the alpha1 ball.
// ----------------------------------------------------------------------------
//  channel | role   | payload
//  pixel   | sink   | pixel, two forward neighbors, aux pair, old dual pair
//  result  | source | projected dual pair, was_projected
//  cfg     | sink   | index 0 step_sigma, index 1 ball_radius
//
// One item per cycle while no result waits in the skid register. Depth is set by the
// square root and the two dividers, each resolving two bits per stage over 32 bits.
// Reset clears the valid bits and loads the register defaults.
// A stalled result parks in a skid register; the pipe then holds until it leaves.
`include "tgv_dual_first_order_update_assert.svh"

module tgv_dual_first_order_update #(
  parameter int FRAC_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  tgv_pix_if.sink   pixel,
  tgv_res_if.source result,
  tgv_cfg_if.sink   cfg
);

  localparam int QW = 68 - FRAC_BITS;
  localparam int AW = QW - 1;
  localparam int KW = $clog2(AW);

  localparam int S_PROD = 1;
  localparam int S_ACC  = 2;
  localparam int S_MAG  = 3;
  localparam int S_SQ   = 4;
  localparam int S_TEST = 5;
  localparam int S_RAD  = 6;
  localparam int SQN    = tgv_pkg::ROOT_BITS / tgv_pkg::BITS_PER_STAGE;
  localparam int SQ0    = S_RAD + 1;
  localparam int DV0    = SQ0 + SQN;
  localparam int FIN    = DV0 + SQN;
  localparam int NS     = FIN + 1;

  typedef struct packed {
    logic [33:0]          m1;
    logic [33:0]          m2;
    logic                 n1;
    logic                 n2;
    logic signed [31:0]   p1;
    logic signed [31:0]   p2;
    logic [49:0]          l1;
    logic [49:0]          h1;
    logic [49:0]          l2;
    logic [49:0]          h2;
    logic signed [QW-1:0] q1;
    logic signed [QW-1:0] q2;
    logic [AW-1:0]        a;
    logic [AW-1:0]        b;
    logic [KW-1:0]        k;
    logic                 fits;
    logic [30:0]          am;
    logic [30:0]          bm;
    logic [63:0]          a2;
    logic [63:0]          b2;
    logic [63:0]          r2;
    logic                 proj;
    logic [61:0]          am2;
    logic [61:0]          bm2;
    logic [62:0]          ar;
    logic [62:0]          br;
    logic [63:0]          sq;
    logic [33:0]          srem;
    logic [31:0]          root;
    logic [31:0]          dn;
    logic [32:0]          dr1;
    logic [32:0]          dr2;
    logic [31:0]          dv1;
    logic [31:0]          dv2;
    logic [31:0]          o1;
    logic [31:0]          o2;
    tgv_pkg::out_item_t   res;
  } pipe_t;

  logic [31:0]        sigma;
  logic [31:0]        radius;
  pipe_t              stg [NS];
  pipe_t              nxt [NS];
  logic [NS-1:0]      vld;
  logic               en;
  logic               skv;
  tgv_pkg::out_item_t skd;

  function automatic logic [31:0] sat_q(input logic signed [QW-1:0] v);
    logic [31:0] r;
    if ((&v[QW-1:31]) || !(|v[QW-1:31])) begin
      r = v[31:0];
    end else begin
      r = v[QW-1] ? tgv_pkg::SAT_MIN : tgv_pkg::SAT_MAX;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_o(input logic neg, input logic [31:0] o);
    logic [31:0] r;
    if (neg) begin
      r = o[31] ? tgv_pkg::SAT_MIN : 32'(-o);
    end else begin
      r = o[31] ? tgv_pkg::SAT_MAX : o;
    end
    return r;
  endfunction

  function automatic pipe_t stage0(input tgv_pkg::in_item_t d);
    pipe_t              x;
    logic signed [33:0] d1;
    logic signed [33:0] d2;
    x  = '0;
    d1 = 34'(d.pixel_next_row) - 34'(d.pixel_here) - 34'(d.aux_first);
    d2 = 34'(d.pixel_next_col) - 34'(d.pixel_here) - 34'(d.aux_second);
    x.n1 = d1[33];
    x.n2 = d2[33];
    x.m1 = d1[33] ? 34'(-d1) : d1;
    x.m2 = d2[33] ? 34'(-d2) : d2;
    x.p1 = d.dual_first_in;
    x.p2 = d.dual_second_in;
    return x;
  endfunction

  function automatic pipe_t stage_fn(input pipe_t t, input int s,
                                     input logic [31:0] sig, input logic [31:0] rad);
    pipe_t         x;
    logic [65:0]   pr1;
    logic [65:0]   pr2;
    logic [65:0]   rr1;
    logic [65:0]   rr2;
    logic [AW-1:0] amax;
    logic [35:0]   srm;
    logic [35:0]   trl;
    logic [32:0]   rm1;
    logic [32:0]   rm2;
    x = t;
    if (s == S_PROD) begin
      x.l1 = 50'(t.m1 * sig[15:0]);
      x.h1 = 50'(t.m1 * sig[31:16]);
      x.l2 = 50'(t.m2 * sig[15:0]);
      x.h2 = 50'(t.m2 * sig[31:16]);
    end else if (s == S_ACC) begin
      pr1  = {t.h1, 16'b0} + 66'(t.l1);
      pr2  = {t.h2, 16'b0} + 66'(t.l2);
      rr1  = pr1 >> FRAC_BITS;
      rr2  = pr2 >> FRAC_BITS;
      x.q1 = t.n1 ? QW'(t.p1) - $signed(rr1[QW-1:0]) : QW'(t.p1) + $signed(rr1[QW-1:0]);
      x.q2 = t.n2 ? QW'(t.p2) - $signed(rr2[QW-1:0]) : QW'(t.p2) + $signed(rr2[QW-1:0]);
    end else if (s == S_MAG) begin
      x.a    = t.q1[QW-1] ? AW'(-t.q1) : AW'(t.q1);
      x.b    = t.q2[QW-1] ? AW'(-t.q2) : AW'(t.q2);
      amax   = (x.a > x.b) ? x.a : x.b;
      x.fits = !(|(amax >> 32));
      x.k    = '0;
      for (int i = 31; i < AW; i++) begin
        if (amax[i]) begin
          x.k = KW'(i - 30);
        end
      end
    end else if (s == S_SQ) begin
      x.a2 = t.a[31:0] * t.a[31:0];
      x.b2 = t.b[31:0] * t.b[31:0];
      x.r2 = rad * rad;
      x.am = 31'(t.a >> t.k);
      x.bm = 31'(t.b >> t.k);
    end else if (s == S_TEST) begin
      x.proj = !t.fits || ((65'(t.a2) + 65'(t.b2)) > 65'(t.r2));
      x.am2  = t.am * t.am;
      x.bm2  = t.bm * t.bm;
      x.ar   = t.am * rad;
      x.br   = t.bm * rad;
    end else if (s == S_RAD) begin
      x.sq   = 64'(t.am2) + 64'(t.bm2);
      x.srem = '0;
      x.root = '0;
    end else if (s >= SQ0 && s < DV0) begin
      for (int j = 0; j < tgv_pkg::BITS_PER_STAGE; j++) begin
        srm  = {x.srem, x.sq[63:62]};
        trl  = {2'b00, x.root, 2'b01};
        x.sq = x.sq << 2;
        if (srm >= trl) begin
          x.srem = 34'(srm - trl);
          x.root = {x.root[30:0], 1'b1};
        end else begin
          x.srem = srm[33:0];
          x.root = {x.root[30:0], 1'b0};
        end
      end
    end else if (s >= DV0 && s < FIN) begin
      if (s == DV0) begin
        x.dn  = (t.root == '0) ? 32'd1 : t.root;
        x.dr1 = {2'b00, t.ar[62:32]};
        x.dr2 = {2'b00, t.br[62:32]};
        x.dv1 = t.ar[31:0];
        x.dv2 = t.br[31:0];
        x.o1  = '0;
        x.o2  = '0;
      end
      for (int j = 0; j < tgv_pkg::BITS_PER_STAGE; j++) begin
        rm1   = {x.dr1[31:0], x.dv1[31]};
        rm2   = {x.dr2[31:0], x.dv2[31]};
        x.dv1 = x.dv1 << 1;
        x.dv2 = x.dv2 << 1;
        x.o1  = {x.o1[30:0], rm1 >= {1'b0, x.dn}};
        x.o2  = {x.o2[30:0], rm2 >= {1'b0, x.dn}};
        x.dr1 = x.o1[0] ? rm1 - {1'b0, x.dn} : rm1;
        x.dr2 = x.o2[0] ? rm2 - {1'b0, x.dn} : rm2;
      end
    end else if (s == FIN) begin
      if (t.proj) begin
        x.res.dual_first_out  = sat_o(t.q1[QW-1], t.o1);
        x.res.dual_second_out = sat_o(t.q2[QW-1], t.o2);
      end else begin
        x.res.dual_first_out  = sat_q(t.q1);
        x.res.dual_second_out = sat_q(t.q2);
      end
      x.res.was_projected = t.proj;
    end
    return x;
  endfunction

  // config registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma  <= tgv_pkg::SIGMA_RESET;
      radius <= tgv_pkg::RADIUS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        tgv_pkg::REG_STEP_SIGMA: begin
          sigma <= cfg.data;
        end
        tgv_pkg::REG_BALL_RADIUS: begin
          radius <= cfg.data;
        end
        default: begin
        end
      endcase
    end
  end

  // pipeline
  assign en          = !skv;
  assign pixel.ready = en;

  always_comb begin
    nxt[0] = stage0(pixel.data);
    for (int s = 1; s < NS; s++) begin
      nxt[s] = stage_fn(stg[s-1], s, sigma, radius);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], pixel.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        stg[s] <= nxt[s];
      end
    end
  end

  // skid register behind the last stage
  always_ff @(posedge clk) begin
    if (rst) begin
      skv <= 1'b0;
    end else if (skv) begin
      skv <= !result.ready;
    end else begin
      skv <= vld[NS-1] && !result.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!skv) begin
      skd <= stg[NS-1].res;
    end
  end

  assign result.valid = skv || vld[NS-1];
  assign result.data  = skv ? skd : stg[NS-1].res;

  `TGV_ASSERT_NEXT(a_enter, pixel.valid && pixel.ready, vld[0], "accepted item not in stage 0")
  `TGV_ASSERT_NEXT(a_skid_hold, skv && !result.ready, skv && $stable(skd), "skid item lost")
  `TGV_ASSERT_NEXT(a_skid_next, skv && result.ready, !skv && result.valid == vld[NS-1], "skid drain order")
  `TGV_ASSERT_NOW(a_ball, result.valid && result.data.was_projected && !radius[31], ($signed(result.data.dual_first_out) <= $signed({1'b0, radius})) && ($signed(result.data.dual_first_out) >= -$signed({1'b0, radius})), "projected value outside ball")
endmodule

[tb/sv/tb_tgv_dual_first_order_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tgv_dual_first_order_update
// Streams pixel items through the dual step under several sigma and radius
// settings and random stalls on both sides. Each result is checked against
// a bit-accurate prediction of the update, projection and saturation.
// ----------------------------------------------------------------------------
module tb_tgv_dual_first_order_update;

  localparam int FRAC    = 16;
  localparam int STALL_LIMIT = 4000;

  logic clk;
  logic rst;

  tgv_pix_if pix ();
  tgv_res_if res ();
  tgv_cfg_if cfg ();

  tgv_dual_first_order_update #(.FRAC_BITS(FRAC)) dut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pix),
    .result(res),
    .cfg   (cfg)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  tgv_pkg::in_item_t  pending_px[$];
  tgv_pkg::out_item_t expected_dual[$];
  logic [31:0]        sigma_q;
  logic [31:0]        radius_q;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 errors;
  int                 quiet_cycles;

  function automatic longint sigma_scale(longint d);
    logic [63:0] m;
    logic [95:0] prod;
    logic [63:0] r;
    m = (d < 0) ? -d : d;
    prod = {32'd0, m} * {64'd0, sigma_q};
    r = 64'(prod >> FRAC);
    return (d < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] acc;
    logic [63:0] bt;
    acc = 64'd0;
    bt = 64'h4000_0000_0000_0000;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= acc + bt) begin
        v = v - (acc + bt);
        acc = (acc >> 1) + bt;
      end else begin
        acc = acc >> 1;
      end
      bt = bt >> 2;
    end
    return acc;
  endfunction

  function automatic logic [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return tgv_pkg::SAT_MAX;
    if (x < -64'sd2147483648) return tgv_pkg::SAT_MIN;
    return x[31:0];
  endfunction

  function automatic tgv_pkg::out_item_t predict_dual(tgv_pkg::in_item_t it);
    tgv_pkg::out_item_t o;
    longint      q1, q2;
    logic [63:0] a, b, amax, as_, bs_, n, o1, o2, r;
    logic [65:0] nsq, rsq;
    int          k;
    logic        proj;
    q1 = longint'(it.dual_first_in) + sigma_scale(
         (longint'(it.pixel_next_row) - longint'(it.pixel_here)) - longint'(it.aux_first));
    q2 = longint'(it.dual_second_in) + sigma_scale(
         (longint'(it.pixel_next_col) - longint'(it.pixel_here)) - longint'(it.aux_second));
    a = (q1 < 0) ? -q1 : q1;
    b = (q2 < 0) ? -q2 : q2;
    amax = (a > b) ? a : b;
    r = {32'd0, radius_q};
    if (amax >= 64'h1_0000_0000) begin
      proj = 1'b1;
    end else begin
      nsq = {2'b0, a * a} + {2'b0, b * b};
      rsq = {2'b0, r * r};
      proj = nsq > rsq;
    end
    if (proj) begin
      k = 0;
      while ((amax >> k) >= 64'h8000_0000) k++;
      as_ = a >> k;
      bs_ = b >> k;
      n = root_floor(as_ * as_ + bs_ * bs_);
      if (n == 0) n = 1;
      o1 = (as_ * r) / n;
      o2 = (bs_ * r) / n;
      o.dual_first_out  = clamp32((q1 < 0) ? -longint'(o1) : longint'(o1));
      o.dual_second_out = clamp32((q2 < 0) ? -longint'(o2) : longint'(o2));
      o.was_projected   = 1'b1;
    end else begin
      o.dual_first_out  = clamp32(q1);
      o.dual_second_out = clamp32(q2);
      o.was_projected   = 1'b0;
    end
    return o;
  endfunction

  function automatic logic [31:0] rand_field();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
    if (sel < 85) return $urandom;
    case ($urandom_range(4))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return 32'h0001_0000;
    endcase
  endfunction

  function automatic tgv_pkg::in_item_t rand_item();
    tgv_pkg::in_item_t it;
    it.pixel_here     = rand_field();
    it.pixel_next_row = rand_field();
    it.pixel_next_col = rand_field();
    it.aux_first      = rand_field();
    it.aux_second     = rand_field();
    it.dual_first_in  = rand_field();
    it.dual_second_in = rand_field();
    return it;
  endfunction

  function automatic tgv_pkg::in_item_t mk_item(logic [31:0] u, logic [31:0] un,
                                                logic [31:0] uc,
                                                logic [31:0] v1, logic [31:0] v2,
                                                logic [31:0] p1, logic [31:0] p2);
    tgv_pkg::in_item_t it;
    it = {u, un, uc, v1, v2, p1, p2};
    return it;
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else begin
      if (pix.valid && pix.ready) begin
        expected_dual.push_back(predict_dual(pix.data));
      end
      if (!pix.valid || pix.ready) begin
        if (pending_px.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          pix.valid <= 1'b1;
          pix.data  <= pending_px.pop_front();
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    tgv_pkg::out_item_t exp_o;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_dual.size() == 0) begin
          $error("result item with no expectation pending");
          errors++;
        end else begin
          exp_o = expected_dual.pop_front();
          if (res.data.dual_first_out !== exp_o.dual_first_out) begin
            $error("dual_first_out expected %h actual %h",
                   exp_o.dual_first_out, res.data.dual_first_out);
            errors++;
          end
          if (res.data.dual_second_out !== exp_o.dual_second_out) begin
            $error("dual_second_out expected %h actual %h",
                   exp_o.dual_second_out, res.data.dual_second_out);
            errors++;
          end
          if (res.data.was_projected !== exp_o.was_projected) begin
            $error("was_projected expected %b actual %b",
                   exp_o.was_projected, res.data.was_projected);
            errors++;
          end
        end
      end
      res.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(tgv_pkg::reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!(cfg.valid && cfg.ready));
    if (idx == tgv_pkg::REG_STEP_SIGMA) sigma_q = val;
    else radius_q = val;
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_px.size() > 0 || pix.valid || expected_dual.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    logic [31:0] sig_set[6];
    logic [31:0] rad_set[6];
    pix.valid = 1'b0;
    pix.data  = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = tgv_pkg::REG_STEP_SIGMA;
    cfg.data  = '0;
    errors = 0;
    quiet_cycles = 0;
    sigma_q  = tgv_pkg::SIGMA_RESET;
    radius_q = tgv_pkg::RADIUS_RESET;
    send_idle_pct = 10;
    recv_idle_pct = 49;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // default registers: zero, extremes, on and just past the radius
    pending_px.push_back(mk_item(0, 0, 0, 0, 0, 0, 0));
    pending_px.push_back(mk_item(0, 0, 0, 0, 0, 32'h0001_0000, 0));
    pending_px.push_back(mk_item(0, 0, 0, 0, 0, 32'h0001_0001, 0));
    pending_px.push_back(mk_item(0, 0, 0, 0, 0, 0, 32'hffff_0000));
    pending_px.push_back(mk_item(0, 0, 0, 0, 0, 32'h0000_b505, 32'h0000_b505));
    pending_px.push_back(mk_item(0, 0, 0, 0, 0, 32'h0000_b504, 32'hffff_4afc));
    pending_px.push_back(mk_item(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                                 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
    pending_px.push_back(mk_item(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                                 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
    pending_px.push_back(mk_item(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    pending_px.push_back(mk_item(32'h0000_1000, 32'h0000_3000, 32'hffff_f000,
                                 32'h0000_0100, 32'hffff_ff00, 32'h0000_2000, 32'hffff_e000));
    pending_px.push_back(mk_item(0, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0));
    for (int i = 0; i < 120; i++) pending_px.push_back(rand_item());
    drain();

    sig_set = '{32'd0, 32'hffff_ffff, 32'h0001_0000, 32'h0000_4000, 32'd1, 32'h0000_8000};
    rad_set = '{32'h0001_0000, 32'd1, 32'hffff_ffff, 32'h0010_0000, 32'h0000_8000, 32'd1};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph >= 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (ph >= 1) begin
        send_idle_pct = 49;
        recv_idle_pct = 10;
      end
      write_reg(tgv_pkg::REG_STEP_SIGMA, (ph == 5) ? $urandom : sig_set[ph]);
      write_reg(tgv_pkg::REG_BALL_RADIUS, (ph == 5) ? ($urandom | 32'd1) : rad_set[ph]);
      pending_px.push_back(mk_item(0, 0, 0, 0, 0, 0, 0));
      pending_px.push_back(mk_item(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                                   32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
      for (int i = 0; i < 110; i++) pending_px.push_back(rand_item());
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/tgv_pkg.sv
rtl/tgv_if.sv
rtl/tgv_dual_first_order_update.sv
tb/sv/tb_tgv_dual_first_order_update.sv
